// ----- hw/rtl/ypd_pkg.sv -----
`timescale 1ns / 1ps

package ypd_pkg;

    localparam logic [7:0] TYPE_SOH = 8'd1;
    localparam logic [7:0] TYPE_STX = 8'd2;
    localparam logic [7:0] TYPE_ETX = 8'd3;
    localparam logic [7:0] TYPE_EOT = 8'd4;
    localparam logic [7:0] TYPE_ENQ = 8'd5;
    localparam logic [7:0] TYPE_ACK = 8'd6;
    localparam logic [7:0] TYPE_NAK = 8'd21;
    localparam logic [7:0] TYPE_CAN = 8'd24;

    // code 0 on a data block stands for a full block
    localparam int unsigned FULL_BLOCK = 256;

    typedef enum logic [1:0] {
        PH_TYPE = 2'd0,
        PH_CODE = 2'd1,
        PH_DATA = 2'd2,
        PH_SUM  = 2'd3
    } phase_t;

    typedef struct packed {
        logic [7:0] packet_type;
        logic [7:0] packet_code;
        logic [7:0] data_byte;
        logic       data_valid;
        logic       last;
        logic       checksum_ok;
        logic       bad_type;
    } result_t;

endpackage

// ----- hw/rtl/ypd_in_if.sv -----
`timescale 1ns / 1ps

interface ypd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

// ----- hw/rtl/ypd_out_if.sv -----
`timescale 1ns / 1ps

interface ypd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] packet_type;
    logic [7:0] packet_code;
    logic [7:0] data_byte;
    logic       data_valid;
    logic       last;
    logic       checksum_ok;
    logic       bad_type;

    modport source (
        output valid, output packet_type, output packet_code, output data_byte,
        output data_valid, output last, output checksum_ok, output bad_type,
        input ready
    );
    modport sink (
        input valid, input packet_type, input packet_code, input data_byte,
        input data_valid, input last, input checksum_ok, input bad_type,
        output ready
    );
endinterface

// ----- hw/rtl/ypd_in_reg.sv -----
`timescale 1ns / 1ps

module ypd_in_reg (
    input  logic        clk,
    input  logic        rst_n,
    ypd_in_if.sink      in_ch,
    input  logic        out_free,
    output logic        step,
    output logic [7:0]  rx_byte
);

    logic       vld_reg;
    logic       vld_next;
    logic [7:0] byte_reg;
    logic       take;

    // the held byte moves on whenever the result register can take its result
    assign step         = vld_reg && out_free;
    assign in_ch.ready  = !vld_reg || out_free;
    assign take         = in_ch.valid && in_ch.ready;
    assign rx_byte      = byte_reg;

    always_comb
    begin
        vld_next = vld_reg;
        if (take)
        begin
            vld_next = 1'b1;
        end
        else if (step)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg <= in_ch.in_byte;
        end
    end

endmodule

// ----- hw/rtl/ypd_parse.sv -----
`timescale 1ns / 1ps

module ypd_parse #(
    parameter int unsigned MAX_BLOCK = 256
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [7:0]       rx_byte,
    output logic             res_valid,
    output ypd_pkg::result_t res
);

    // counter must hold a full data block and any header/NAK/cancel length
    localparam int unsigned BLK_W = $clog2(MAX_BLOCK + 1);
    localparam int unsigned CNT_W = (BLK_W > 8) ? BLK_W : 8;

    ypd_pkg::phase_t phase_reg;
    ypd_pkg::phase_t phase_next;
    logic [7:0]      type_reg;
    logic [7:0]      type_next;
    logic [7:0]      code_reg;
    logic [7:0]      code_next;
    logic [CNT_W-1:0] left_reg;
    logic [CNT_W-1:0] left_next;
    logic [7:0]      sum_reg;
    logic [7:0]      sum_next;

    logic [8:0]       blk_len;
    logic             oversize;
    logic             is_stx;
    logic             is_var;
    logic             is_short;
    logic [CNT_W-1:0] left_dec;
    logic             left_done;

    assign is_stx   = (type_reg == ypd_pkg::TYPE_STX);
    assign is_var   = (type_reg == ypd_pkg::TYPE_SOH) || (type_reg == ypd_pkg::TYPE_NAK)
                   || (type_reg == ypd_pkg::TYPE_CAN);
    assign is_short = (type_reg == ypd_pkg::TYPE_ACK) || (type_reg == ypd_pkg::TYPE_ENQ)
                   || (type_reg == ypd_pkg::TYPE_ETX) || (type_reg == ypd_pkg::TYPE_EOT);
    assign blk_len  = (rx_byte == 8'd0) ? 9'(ypd_pkg::FULL_BLOCK) : {1'b0, rx_byte};
    assign oversize = ({23'd0, blk_len} > 32'(MAX_BLOCK));
    assign left_dec = (left_reg != '0) ? (left_reg - CNT_W'(1)) : left_reg;
    assign left_done = (left_dec == '0);

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (step)
        begin
            case (phase_reg)
                ypd_pkg::PH_TYPE:
                begin
                    phase_next = ypd_pkg::PH_CODE;
                end
                ypd_pkg::PH_CODE:
                begin
                    if ((is_stx && !oversize) || (is_var && rx_byte != 8'd0))
                    begin
                        phase_next = ypd_pkg::PH_DATA;
                    end
                    else
                    begin
                        phase_next = ypd_pkg::PH_TYPE;
                    end
                end
                ypd_pkg::PH_DATA:
                begin
                    if (left_done)
                    begin
                        phase_next = is_stx ? ypd_pkg::PH_SUM : ypd_pkg::PH_TYPE;
                    end
                end
                default:
                begin
                    phase_next = ypd_pkg::PH_TYPE;
                end
            endcase
        end
    end

    // packet register next values and the combinational result
    always_comb
    begin
        type_next       = type_reg;
        code_next       = code_reg;
        left_next       = left_reg;
        sum_next        = sum_reg;
        res_valid       = 1'b0;
        res.packet_type = type_reg;
        res.packet_code = code_reg;
        res.data_byte   = 8'd0;
        res.data_valid  = 1'b0;
        res.last        = 1'b0;
        res.checksum_ok = 1'b0;
        res.bad_type    = 1'b0;
        case (phase_reg)
            ypd_pkg::PH_TYPE:
            begin
                if (step)
                begin
                    type_next = rx_byte;
                end
            end
            ypd_pkg::PH_CODE:
            begin
                res.packet_code = rx_byte;
                if (step)
                begin
                    code_next = rx_byte;
                end
                if (is_stx && !oversize)
                begin
                    if (step)
                    begin
                        left_next = CNT_W'(blk_len);
                        sum_next  = 8'd0;
                    end
                end
                else if (is_var && rx_byte != 8'd0)
                begin
                    if (step)
                    begin
                        left_next = CNT_W'(rx_byte);
                    end
                end
                else if ((is_var || is_short) && !is_stx)
                begin
                    res_valid       = step;
                    res.last        = 1'b1;
                    res.checksum_ok = 1'b1;
                end
                else
                begin
                    // unknown type or oversized block: flag and drop
                    res_valid    = step;
                    res.bad_type = 1'b1;
                end
            end
            ypd_pkg::PH_DATA:
            begin
                res_valid      = step;
                res.data_byte  = rx_byte;
                res.data_valid = 1'b1;
                if (step)
                begin
                    left_next = left_dec;
                    if (is_stx)
                    begin
                        sum_next = sum_reg + rx_byte;
                    end
                end
                if (!is_stx && left_done)
                begin
                    res.last        = 1'b1;
                    res.checksum_ok = 1'b1;
                end
            end
            default:
            begin
                res_valid       = step;
                res.last        = 1'b1;
                res.checksum_ok = (rx_byte == sum_reg);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= ypd_pkg::PH_TYPE;
            type_reg  <= 8'd0;
            code_reg  <= 8'd0;
            left_reg  <= '0;
            sum_reg   <= 8'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            type_reg  <= type_next;
            code_reg  <= code_next;
            left_reg  <= left_next;
            sum_reg   <= sum_next;
        end
    end

`ifndef ASSERT_OFF
    a_type_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == ypd_pkg::PH_TYPE) |-> !res_valid)
        else $error("result raised on a type byte");

    // the checksum phase may be held while the output stalls
    a_sum_after_data: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == ypd_pkg::PH_SUM) |->
        (($past(phase_reg) == ypd_pkg::PH_DATA) || ($past(phase_reg) == ypd_pkg::PH_SUM))
        && (type_reg == ypd_pkg::TYPE_STX))
        else $error("checksum phase not entered from a data block");

    a_bad_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.bad_type) |=> (phase_reg == ypd_pkg::PH_TYPE))
        else $error("dropped packet did not return to type byte");

    a_data_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == ypd_pkg::PH_DATA) |-> (left_reg != '0))
        else $error("data phase with no bytes left");
`endif

endmodule

// ----- hw/rtl/ypd_out_reg.sv -----
`timescale 1ns / 1ps

module ypd_out_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             res_valid,
    input  ypd_pkg::result_t res,
    output logic             out_free,
    ypd_out_if.source        out_ch
);

    logic             vld_reg;
    logic             vld_next;
    ypd_pkg::result_t res_reg;

    assign out_free = !vld_reg || out_ch.ready;

    always_comb
    begin
        vld_next = vld_reg;
        if (res_valid)
        begin
            vld_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            res_reg <= res;
        end
    end

    assign out_ch.valid       = vld_reg;
    assign out_ch.packet_type = res_reg.packet_type;
    assign out_ch.packet_code = res_reg.packet_code;
    assign out_ch.data_byte   = res_reg.data_byte;
    assign out_ch.data_valid  = res_reg.data_valid;
    assign out_ch.last        = res_reg.last;
    assign out_ch.checksum_ok = res_reg.checksum_ok;
    assign out_ch.bad_type    = res_reg.bad_type;

endmodule

// ----- hw/rtl/yapp_c_packet_deframer_core.sv -----
`timescale 1ns / 1ps

// Packet deframer for a YAPP-C byte stream.
// in_ch carries one received link byte per beat. out_ch carries at most one
// result beat per input byte: payload bytes as they arrive, a closing beat with
// last set (checksum_ok checks the block sum, or is 1 with no sum), or a
// bad_type beat on the code byte of an unknown or oversized packet. Type bytes
// give no beat. A byte passes two register stages, byte register then result
// register, before its result shows on out_ch.
// Throughput: one byte per cycle while out_ch is ready; the phase/count/sum
// update is a single pass of logic between the byte and result registers.
// Reset: both stages empty, parser waits for a type byte, counters cleared.
// When the receiver stalls, the result register holds its beat, the byte
// register keeps the next byte and in_ch.ready drops once both are full;
// ready on in_ch follows ready on out_ch combinationally when both are full.
// MAX_BLOCK (1..256) is the largest data block taken; longer ones are dropped.

module yapp_c_packet_deframer_core #(
    parameter int unsigned MAX_BLOCK = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    ypd_in_if.sink     in_ch,
    ypd_out_if.source  out_ch
);

    logic             out_free;
    logic             step;
    logic [7:0]       rx_byte;
    logic             res_valid;
    ypd_pkg::result_t res;

    ypd_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .out_free (out_free),
        .step     (step),
        .rx_byte  (rx_byte)
    );

    ypd_parse #(
        .MAX_BLOCK (MAX_BLOCK)
    ) u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .rx_byte   (rx_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    ypd_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .out_free  (out_free),
        .out_ch    (out_ch)
    );

`ifndef ASSERT_OFF
    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> (out_ch.valid && !out_ch.ready))
        else $error("input stalled with room in the result register");

    a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |=> out_ch.valid)
        else $error("result beat lost");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.ready) |-> !res_valid)
        else $error("result register overwritten while stalled");
`endif

endmodule
